>>> hdl/scanpf_pkg.sv
// ----------------------------------------------------------------------------
// Scanline polygon fill package
// Opcodes, register constants and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package scanpf_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    // Line step register.
    localparam int unsigned STEP_W = 15;
    localparam logic [STEP_W-1:0] STEP_RESET = 15'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;        // empty the polygon
        logic add_vtx;    // store the incoming vertex
        logic set_ovf;    // a vertex was dropped
        logic vrd;        // read the vertex store
        logic lat_a;      // latch the first vertex of the edge
        logic edge_prep;  // form the edge operands
        logic mul;        // multiply and start the divide
        logic div_step;   // one restoring divide step
        logic fin;        // form the crossing
        logic brd;        // read the crossing buffer
        logic ins_shift;  // move an entry up by one
        logic ins_put;    // place the crossing and count it
        logic line_end;   // advance to the next line
        logic lat_left;   // latch the left end of a span
        logic load_span;  // present a span result
        logic load_empty; // present a line without spans
        logic load_done;  // present a finished-fill result
        logic last;       // result closes the scan item
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_ok;  // enough vertices and line within bounds
        logic full;     // vertex store is full
        logic hit;      // edge crosses the current line
        logic horiz;    // edge is horizontal
        logic gt;       // buffer entry lies right of the new crossing
        logic out_free; // output register can take a result
    } t_sts;

endpackage

>>> hdl/scanline_polygon_fill_spans_top.sv
// ----------------------------------------------------------------------------
// Scanline polygon fill span generator, top level
// Collects polygon vertices and, per scan beat, emits the fill spans of one
// horizontal line, or a finished-fill result when no line can be scanned.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_stall) takes one beat per command:
// clear, add vertex or scan next line. Clear and add vertex finish in the
// cycle they are taken and produce no output. A scan beat walks every edge
// of the polygon; an edge that crosses the line and is not horizontal runs
// the bit-serial divider, and each crossing is inserted in sorted order
// through the single port of the crossing buffer. Spans then leave one at
// a time, each read from the buffer, on the output channel (o_out_valid /
// i_out_stall); the last beat of a line has o_last_of_line set. The input
// channel stalls until the last result of a scan beat has entered the
// output register. When the receiver stalls, the output register holds its
// beat and the block waits. The user must write the line step register over
// i_cfg_valid / o_cfg_ready only while the block is idle; the block itself
// does not enforce this. Synchronous reset clears the polygon, the bounds,
// the overflow flag and the output valid, and sets the line step to 16.
// ----------------------------------------------------------------------------
module scanline_polygon_fill_spans_top #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_opcode,
    input  logic signed [COORD_BITS-1:0]        i_vertex_x,
    input  logic signed [COORD_BITS-1:0]        i_vertex_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [scanpf_pkg::STEP_W-1:0]       i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [COORD_BITS-1:0]        o_span_left_x,
    output logic signed [COORD_BITS-1:0]        o_span_right_x,
    output logic signed [COORD_BITS-1:0]        o_span_y,
    output logic                                o_span_valid,
    output logic                                o_last_of_line,
    output logic                                o_fill_done,
    output logic                                o_vertex_overflow
);

    localparam int AW = $clog2(MAX_VERTICES);

    scanpf_pkg::t_cmd cmd;
    scanpf_pkg::t_sts sts;
    logic [AW-1:0]    vaddr, baddr;
    logic [AW:0]      vcnt, ccnt;
    logic             idle, accept;

    // Input beats are taken only while the controller is idle.
    assign o_in_stall  = !idle;
    assign accept      = i_in_valid && idle;
    assign o_cfg_ready = 1'b1;

    scanpf_ctrl #(
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .i_vcnt   (vcnt),
        .i_ccnt   (ccnt),
        .o_cmd    (cmd),
        .o_vaddr  (vaddr),
        .o_baddr  (baddr),
        .o_idle   (idle)
    );

    scanpf_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS),
        .AW           (AW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_vaddr           (vaddr),
        .i_baddr           (baddr),
        .o_vcnt            (vcnt),
        .o_ccnt            (ccnt),
        .i_vertex_x        (i_vertex_x),
        .i_vertex_y        (i_vertex_y),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_span_left_x     (o_span_left_x),
        .o_span_right_x    (o_span_right_x),
        .o_span_y          (o_span_y),
        .o_span_valid      (o_span_valid),
        .o_last_of_line    (o_last_of_line),
        .o_fill_done       (o_fill_done),
        .o_vertex_overflow (o_vertex_overflow)
    );

endmodule

>>> hdl/scanpf_dp.sv
// ----------------------------------------------------------------------------
// Scanline polygon fill datapath
// Vertex store, crossing buffer, bounds, edge arithmetic with a bit-serial
// divider, and the output register.
// ----------------------------------------------------------------------------
module scanpf_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16,
    parameter int AW           = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  scanpf_pkg::t_cmd                   i_cmd,
    output scanpf_pkg::t_sts                   o_sts,
    input  logic [AW-1:0]                      i_vaddr,
    input  logic [AW-1:0]                      i_baddr,
    output logic [AW:0]                        o_vcnt,
    output logic [AW:0]                        o_ccnt,
    input  logic signed [COORD_BITS-1:0]       i_vertex_x,
    input  logic signed [COORD_BITS-1:0]       i_vertex_y,
    input  logic                               i_cfg_we,
    input  logic [scanpf_pkg::STEP_W-1:0]      i_cfg_data,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic signed [COORD_BITS-1:0]       o_span_left_x,
    output logic signed [COORD_BITS-1:0]       o_span_right_x,
    output logic signed [COORD_BITS-1:0]       o_span_y,
    output logic                               o_span_valid,
    output logic                               o_last_of_line,
    output logic                               o_fill_done,
    output logic                               o_vertex_overflow
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int CY = ((C > 16) ? C : 16) + 1;

    // Memories.
    logic [2*C-1:0] r_vmem [MAX_VERTICES];
    logic [C-1:0]   r_bmem [MAX_VERTICES];
    logic [2*C-1:0] r_vrd;
    logic signed [C-1:0] r_brd;

    // Control state.
    logic [AW:0]          r_vcnt, r_ccnt;
    logic signed [C-1:0]  r_min, r_max;
    logic signed [CY-1:0] r_cur;
    logic                 r_ovf;
    logic [scanpf_pkg::STEP_W-1:0] r_step;

    // Payload registers.
    logic signed [C-1:0] r_x1, r_y1, r_x, r_left, r_line_y;
    logic [D-1:0]        r_ua, r_udx, r_udy, r_rem;
    logic [2*D-1:0]      r_prod, r_q;
    logic                r_neg, r_hit, r_horiz, r_done;

    // Output register.
    logic                r_out_valid;
    logic signed [C-1:0] r_o_l, r_o_r, r_o_y;
    logic                r_o_sv, r_o_last, r_o_done, r_o_ovf;

    // Edge operands from the latched first vertex and the read second one.
    logic signed [C-1:0] x2, y2, ly;
    logic signed [D-1:0] dy, dx, da;
    logic                hit;
    always_comb begin
        x2 = r_vrd[2*C-1:C];
        y2 = r_vrd[C-1:0];
        ly = r_cur[C-1:0];
        dy = {y2[C-1], y2} - {r_y1[C-1], r_y1};
        dx = {x2[C-1], x2} - {r_x1[C-1], r_x1};
        da = {ly[C-1], ly} - {r_y1[C-1], r_y1};
        hit = ((r_y1 <= ly) && (y2 >= ly)) || ((y2 <= ly) && (r_y1 >= ly));
    end

    // One restoring divide step.
    logic [D:0] dtrial;
    logic       dge;
    always_comb begin
        dtrial = {r_rem, r_prod[2*D-1]};
        dge    = dtrial >= {1'b0, r_udy};
    end

    // Crossing from quotient and sign.
    logic signed [D:0] xsum, x1e, qe;
    always_comb begin
        x1e  = {r_x1[C-1], r_x1[C-1], r_x1};
        qe   = {1'b0, r_q[D-1:0]};
        xsum = r_neg ? (x1e - qe) : (x1e + qe);
    end

    // Next line.
    logic signed [CY-1:0] nxt, maxe;
    logic [scanpf_pkg::STEP_W-1:0] step_eff;
    always_comb begin
        step_eff = (r_step == '0) ? scanpf_pkg::STEP_W'(1) : r_step;
        maxe     = CY'(r_max);
        nxt      = r_cur + $signed(CY'(step_eff));
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // Status.
    always_comb begin
        o_sts.scan_ok  = (r_vcnt >= (AW+1)'(3)) && !(r_cur > maxe);
        o_sts.full     = (r_vcnt == (AW+1)'(MAX_VERTICES));
        o_sts.hit      = r_hit;
        o_sts.horiz    = r_horiz;
        o_sts.gt       = r_brd > r_x;
        o_sts.out_free = out_free;
    end
    assign o_vcnt = r_vcnt;
    assign o_ccnt = r_ccnt;

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_vtx) begin
            r_vmem[r_vcnt[AW-1:0]] <= {i_vertex_x, i_vertex_y};
        end
        if (i_cmd.vrd) begin
            r_vrd <= r_vmem[i_vaddr];
        end
        if (i_cmd.ins_shift) begin
            r_bmem[i_baddr] <= r_brd;
        end else if (i_cmd.ins_put) begin
            r_bmem[i_baddr] <= r_x;
        end
        if (i_cmd.brd) begin
            r_brd <= r_bmem[i_baddr];
        end
    end

    // Polygon state and line tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0;
            r_ccnt <= '0;
            r_min  <= '0;
            r_max  <= '0;
            r_cur  <= '0;
            r_ovf  <= 1'b0;
            r_step <= scanpf_pkg::STEP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_data;
            end
            if (i_cmd.clr) begin
                r_vcnt <= '0;
                r_ccnt <= '0;
                r_min  <= '0;
                r_max  <= '0;
                r_cur  <= '0;
                r_ovf  <= 1'b0;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.add_vtx) begin
                r_vcnt <= r_vcnt + 1'b1;
                if (r_vcnt == '0 || i_vertex_y < r_min) begin
                    r_min <= i_vertex_y;
                    r_cur <= CY'(i_vertex_y);
                end else begin
                    r_cur <= CY'(r_min);
                end
                if (r_vcnt == '0 || i_vertex_y > r_max) begin
                    r_max <= i_vertex_y;
                end
            end
            if (i_cmd.ins_put) begin
                r_ccnt <= r_ccnt + 1'b1;
            end
            if (i_cmd.line_end) begin
                r_cur <= nxt;
            end
            // The buffer empties once the last result of a line is loaded.
            if (i_cmd.load_empty || (i_cmd.load_span && i_cmd.last)) begin
                r_ccnt <= '0;
            end
        end
    end

    // Edge arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_a) begin
            r_x1 <= r_vrd[2*C-1:C];
            r_y1 <= r_vrd[C-1:0];
        end
        if (i_cmd.edge_prep) begin
            r_hit   <= hit;
            r_horiz <= (dy == '0);
            r_ua    <= da[D-1] ? D'(-da) : D'(da);
            r_udx   <= dx[D-1] ? D'(-dx) : D'(dx);
            r_udy   <= dy[D-1] ? D'(-dy) : D'(dy);
            r_neg   <= da[D-1] ^ dx[D-1] ^ dy[D-1];
        end
        if (i_cmd.mul) begin
            r_prod <= r_ua * r_udx;
            r_rem  <= '0;
            r_q    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= dge ? D'(dtrial - {1'b0, r_udy}) : D'(dtrial);
            r_prod <= {r_prod[2*D-2:0], 1'b0};
            r_q    <= {r_q[2*D-2:0], dge};
        end
        if (i_cmd.fin) begin
            r_x <= r_horiz ? r_x1 : xsum[C-1:0];
        end
        if (i_cmd.line_end) begin
            r_line_y <= ly;
            r_done   <= nxt > maxe;
        end
        if (i_cmd.lat_left) begin
            r_left <= r_brd;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_span || i_cmd.load_empty || i_cmd.load_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_span) begin
            r_o_l    <= r_left;
            r_o_r    <= r_brd;
            r_o_y    <= r_line_y;
            r_o_sv   <= 1'b1;
            r_o_last <= i_cmd.last;
            r_o_done <= r_done;
            r_o_ovf  <= r_ovf;
        end else if (i_cmd.load_empty) begin
            r_o_l    <= '0;
            r_o_r    <= '0;
            r_o_y    <= r_line_y;
            r_o_sv   <= 1'b0;
            r_o_last <= 1'b1;
            r_o_done <= r_done;
            r_o_ovf  <= r_ovf;
        end else if (i_cmd.load_done) begin
            r_o_l    <= '0;
            r_o_r    <= '0;
            r_o_y    <= '0;
            r_o_sv   <= 1'b0;
            r_o_last <= 1'b1;
            r_o_done <= 1'b1;
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_span_left_x     = r_o_l;
    assign o_span_right_x    = r_o_r;
    assign o_span_y          = r_o_y;
    assign o_span_valid      = r_o_sv;
    assign o_last_of_line    = r_o_last;
    assign o_fill_done       = r_o_done;
    assign o_vertex_overflow = r_o_ovf;

endmodule

>>> hdl/scanpf_ctrl.sv
// ----------------------------------------------------------------------------
// Scanline polygon fill controller
// Sequences vertex storage, the per-edge crossing computation, sorted
// insertion into the crossing buffer and span output.
// ----------------------------------------------------------------------------
module scanpf_ctrl #(
    parameter int COORD_BITS = 16,
    parameter int AW         = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_opcode,
    input  scanpf_pkg::t_sts  i_sts,
    input  logic [AW:0]       i_vcnt,
    input  logic [AW:0]       i_ccnt,
    output scanpf_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]     o_vaddr,
    output logic [AW-1:0]     o_baddr,
    output logic              o_idle
);

    localparam int D  = COORD_BITS + 1;
    localparam int BW = $clog2(2 * D);

    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_RD_I  = 16'b0000_0000_0000_0010,
        ST_RD_J  = 16'b0000_0000_0000_0100,
        ST_EDGE  = 16'b0000_0000_0000_1000,
        ST_CHK   = 16'b0000_0000_0001_0000,
        ST_DIV   = 16'b0000_0000_0010_0000,
        ST_FIN   = 16'b0000_0000_0100_0000,
        ST_INS   = 16'b0000_0000_1000_0000,
        ST_CMP   = 16'b0000_0001_0000_0000,
        ST_NEXT  = 16'b0000_0010_0000_0000,
        ST_LEND  = 16'b0000_0100_0000_0000,
        ST_OUT_L = 16'b0000_1000_0000_0000,
        ST_OUT_R = 16'b0001_0000_0000_0000,
        ST_OUT_W = 16'b0010_0000_0000_0000,
        ST_EMPTY = 16'b0100_0000_0000_0000,
        ST_DONE  = 16'b1000_0000_0000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_i, n_i, r_k, n_k, r_sc, n_sc;
    logic [BW-1:0] r_bit, n_bit;

    logic          last_edge, last_span;
    logic [AW:0]   spans;
    logic [AW-1:0] i_next;

    always_comb begin
        last_edge = ((AW+1)'(r_i) + 1'b1) == i_vcnt;
        i_next    = last_edge ? '0 : r_i + 1'b1;
        spans     = i_ccnt >> 1;
        last_span = ((AW+1)'(r_sc) + 1'b1) == spans;
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_k     = r_k;
        n_sc    = r_sc;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_vaddr = r_i;
        o_baddr = r_k;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    case (i_opcode)
                        scanpf_pkg::OP_CLEAR: begin
                            o_cmd.clr = 1'b1;
                        end
                        scanpf_pkg::OP_ADD: begin
                            o_cmd.add_vtx = !i_sts.full;
                            o_cmd.set_ovf = i_sts.full;
                        end
                        scanpf_pkg::OP_SCAN: begin
                            if (i_sts.scan_ok) begin
                                n_i     = '0;
                                n_state = ST_RD_I;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_I: begin
                o_cmd.vrd = 1'b1;
                n_state   = ST_RD_J;
            end
            ST_RD_J: begin
                o_cmd.vrd   = 1'b1;
                o_vaddr     = i_next;
                o_cmd.lat_a = 1'b1;
                n_state     = ST_EDGE;
            end
            ST_EDGE: begin
                o_cmd.edge_prep = 1'b1;
                n_state         = ST_CHK;
            end
            ST_CHK: begin
                if (!i_sts.hit) begin
                    n_state = ST_NEXT;
                end else if (i_sts.horiz) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_bit     = '0;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit          = r_bit + 1'b1;
                if (r_bit == BW'(2 * D - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_k       = i_ccnt[AW-1:0];
                n_state   = ST_INS;
            end
            ST_INS: begin
                if (r_k == '0) begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = ST_NEXT;
                end else begin
                    o_cmd.brd = 1'b1;
                    o_baddr   = r_k - 1'b1;
                    n_state   = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.gt) begin
                    o_cmd.ins_shift = 1'b1;
                    n_k             = r_k - 1'b1;
                    n_state         = ST_INS;
                end else begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (last_edge) begin
                    n_state = ST_LEND;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_RD_I;
                end
            end
            ST_LEND: begin
                o_cmd.line_end = 1'b1;
                n_sc           = '0;
                n_state        = (spans == '0) ? ST_EMPTY : ST_OUT_L;
            end
            ST_OUT_L: begin
                o_cmd.brd = 1'b1;
                o_baddr   = {r_sc[AW-2:0], 1'b0};
                n_state   = ST_OUT_R;
            end
            ST_OUT_R: begin
                o_cmd.brd      = 1'b1;
                o_baddr        = {r_sc[AW-2:0], 1'b1};
                o_cmd.lat_left = 1'b1;
                n_state        = ST_OUT_W;
            end
            ST_OUT_W: begin
                if (i_sts.out_free) begin
                    o_cmd.load_span = 1'b1;
                    o_cmd.last      = last_span;
                    if (last_span) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_sc    = r_sc + 1'b1;
                        n_state = ST_OUT_L;
                    end
                end
            end
            ST_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_empty = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_done = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_k     <= '0;
            r_sc    <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
            r_sc    <= n_sc;
            r_bit   <= n_bit;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

>>> hdl/scanpf_checker.sv
// ----------------------------------------------------------------------------
// Scanline polygon fill port checker
// Watches the top-level ports for ordering, stall and result consistency.
// ----------------------------------------------------------------------------
module scanpf_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic signed [COORD_BITS-1:0] o_span_left_x,
    input logic signed [COORD_BITS-1:0] o_span_right_x,
    input logic                         o_span_valid,
    input logic                         o_last_of_line
);

    // A stalled output beat stays presented.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped under stall");

    // No output beat right after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A beat without a span always closes its line.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_span_valid |-> o_last_of_line)
        else $error("empty result not marked last");

    // Spans come from a sorted buffer.
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_span_valid |-> o_span_left_x <= o_span_right_x)
        else $error("span ends out of order");

endmodule

bind scanline_polygon_fill_spans_top scanpf_checker #(
    .COORD_BITS (COORD_BITS)
) u_scanpf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_span_left_x  (o_span_left_x),
    .o_span_right_x (o_span_right_x),
    .o_span_valid   (o_span_valid),
    .o_last_of_line (o_last_of_line)
);
